// ----- rtl/core/process_id_slot_table_assert.svh -----
// Assertion macros shared by the process table RTL.
// Each macro checks one implication on the rising edge of clk while rst_n is high.
`ifndef PROCESS_ID_SLOT_TABLE_ASSERT_SVH
`define PROCESS_ID_SLOT_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

`define PST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define PST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define PST_ASSERT_SAME(label, ante, cons, msg)

`define PST_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/core/pst_pkg.sv -----
`timescale 1ns / 1ps

package pst_pkg;

  localparam int DEF_SLOT_COUNT = 64;
  localparam int DEF_PID_COUNT  = 32;

  localparam int W_OPCODE = 4;
  localparam int W_TPID   = 8;
  localparam int W_STATE  = 3;
  localparam int W_EXIT   = 32;
  localparam int W_STATUS = 3;
  localparam int W_RPID   = 5;
  localparam int W_SLOT   = 7;
  localparam int W_PARENT = 8;
  localparam int W_COUNT  = 7;

  localparam logic [W_SLOT-1:0] NO_SLOT = 7'd64;

  typedef enum logic [W_OPCODE-1:0] {
    OP_SPAWN       = 4'd0,
    OP_FORK        = 4'd1,
    OP_SET_STATE   = 4'd2,
    OP_EXIT        = 4'd3,
    OP_REAP        = 4'd4,
    OP_LOOKUP      = 4'd5,
    OP_COUNT_STATE = 4'd6,
    OP_COUNT_LIVE  = 4'd7,
    OP_SET_CURRENT = 4'd8
  } opcode_t;

  localparam logic [W_STATUS-1:0] ST_OK         = 3'd0;
  localparam logic [W_STATUS-1:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [W_STATUS-1:0] ST_NO_SLOT    = 3'd2;
  localparam logic [W_STATUS-1:0] ST_NO_PID     = 3'd3;
  localparam logic [W_STATUS-1:0] ST_NOT_ZOMBIE = 3'd4;

  localparam logic [W_STATE-1:0] PS_UNUSED   = 3'd0;
  localparam logic [W_STATE-1:0] PS_RUNNABLE = 3'd1;
  localparam logic [W_STATE-1:0] PS_ZOMBIE   = 3'd4;

endpackage

// ----- rtl/core/pst_in_if.sv -----
`timescale 1ns / 1ps

interface pst_in_if import pst_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [W_OPCODE-1:0]        opcode;
  logic [W_TPID-1:0]          target_pid;
  logic [W_STATE-1:0]         new_state;
  logic signed [W_EXIT-1:0]   exit_value;

  modport source (output valid, opcode, target_pid, new_state, exit_value, input ready);
  modport sink (input valid, opcode, target_pid, new_state, exit_value, output ready);
endinterface

// ----- rtl/core/pst_out_if.sv -----
`timescale 1ns / 1ps

interface pst_out_if import pst_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [W_STATUS-1:0]        status;
  logic [W_RPID-1:0]          result_pid;
  logic [W_SLOT-1:0]          result_slot;
  logic [W_PARENT-1:0]        parent_pid;
  logic [W_STATE-1:0]         proc_state;
  logic signed [W_EXIT-1:0]   exit_result;
  logic [W_COUNT-1:0]         process_count;

  modport source (output valid, status, result_pid, result_slot, parent_pid, proc_state,
                  exit_result, process_count, input ready);
  modport sink (input valid, status, result_pid, result_slot, parent_pid, proc_state,
                exit_result, process_count, output ready);
endinterface

// ----- rtl/core/process_id_slot_table.sv -----
// Table operations: the pid map is read in S_MAP, the slot record in S_SLOT, and the result is registered in S_EVAL,
// which holds while an earlier result is not taken; a new transaction is accepted only back in S_IDLE. Counts walk
// the slot record memory one entry a cycle in S_CNT, as the record memory has a single read port.
// Reset (synchronous, rst_n low) clears the slot bitmap, the pid bitmap except reserved pid 0,
// the current pid and the handshake; the memories are not cleared, since an entry is only read
// behind a set bitmap bit.
`timescale 1ns / 1ps
`include "process_id_slot_table_assert.svh"

module process_id_slot_table import pst_pkg::*; #(
  parameter int SLOT_COUNT = DEF_SLOT_COUNT,
  parameter int PID_COUNT  = DEF_PID_COUNT
) (
  input  logic      clk,
  input  logic      rst_n,
  pst_in_if.sink    in_ch,
  pst_out_if.source out_ch
);

  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int CW  = $clog2(SLOT_COUNT + 1);
  localparam int PIW = $clog2(PID_COUNT);

  typedef enum logic [2:0] {S_IDLE, S_MAP, S_SLOT, S_CNT, S_EVAL} seq_state_t;

  typedef struct packed {
    logic [PIW-1:0]      owner;
    logic [W_PARENT-1:0] parent;
    logic [W_STATE-1:0]  pstate;
    logic [W_EXIT-1:0]   exit_word;
  } rec_t;

  typedef struct packed {
    logic [W_STATUS-1:0] status;
    logic [W_RPID-1:0]   rpid;
    logic [W_SLOT-1:0]   slot;
    logic [W_PARENT-1:0] parent;
    logic [W_STATE-1:0]  pstate;
    logic [W_EXIT-1:0]   exit_word;
    logic [W_COUNT-1:0]  count;
  } result_t;

  seq_state_t state_r, state_nxt;

  logic [W_OPCODE-1:0] op_r;
  logic [W_TPID-1:0]   pid_r;
  logic [W_STATE-1:0]  nst_r;
  logic [W_EXIT-1:0]   ev_r;
  logic [W_TPID-1:0]   current_r;

  logic [SLOT_COUNT-1:0] slot_used_r;
  logic [PID_COUNT-1:0]  pid_used_r;

  logic [SW-1:0]  free_slot_r, free_slot_c;
  logic           slot_avail_r, slot_avail_c;
  logic [PIW-1:0] free_pid_r, free_pid_c;
  logic           pid_avail_r, pid_avail_c;

  logic [CW-1:0] cnt_r;
  logic          pend_r;
  logic [SW-1:0] pend_idx_r;
  logic [CW-1:0] count_r;
  logic          cnt_hit;

  logic    out_valid_r;
  result_t res_r, res_c;

  // Pid-to-slot map and per-slot records.
  logic [SW-1:0] map_mem [PID_COUNT];
  logic [SW-1:0] map_q;
  rec_t          rec_mem [SLOT_COUNT];
  rec_t          rec_q;

  logic          map_we;
  logic          rec_we;
  logic          rec_re;
  logic [SW-1:0] rec_wa;
  logic [SW-1:0] rec_ra;
  rec_t          rec_wd;

  logic           accept;
  logic           fire;
  logic [W_TPID-1:0] lookup_pid;
  logic [PIW-1:0] lk_idx;
  logic           pid_ok;
  logic           map_hit;
  logic           live;
  logic           do_create;
  logic           do_update;
  logic           do_reap;
  logic           do_setcur;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign fire        = (state_r == S_EVAL) && (!out_valid_r || out_ch.ready);

  // Fork looks up the current process; the other operations look up the target.
  assign lookup_pid = (op_r == OP_FORK) ? current_r : pid_r;
  assign lk_idx     = PIW'(lookup_pid);
  assign pid_ok     = (lookup_pid != '0) && (9'(lookup_pid) < 9'(PID_COUNT));
  assign map_hit    = pid_ok && pid_used_r[lk_idx];
  assign live       = map_hit && (rec_q.owner == lk_idx) && (rec_q.pstate != PS_UNUSED);

  // Lowest free slot and lowest free pid; pid 0 stays marked as used.
  always_comb begin
    slot_avail_c = 1'b0;
    free_slot_c  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_used_r[i]) begin
        slot_avail_c = 1'b1;
        free_slot_c  = SW'(i);
      end
    end
  end

  always_comb begin
    pid_avail_c = 1'b0;
    free_pid_c  = '0;
    for (int i = PID_COUNT - 1; i >= 0; i--) begin
      if (!pid_used_r[i]) begin
        pid_avail_c = 1'b1;
        free_pid_c  = PIW'(i);
      end
    end
  end

  // An unused slot counts as state zero.
  always_comb begin
    cnt_hit = 1'b0;
    if (pend_r) begin
      if (slot_used_r[pend_idx_r]) begin
        if (op_r == OP_COUNT_STATE) begin
          cnt_hit = (rec_q.pstate == nst_r);
        end else begin
          cnt_hit = (rec_q.pstate != PS_UNUSED);
        end
      end else begin
        cnt_hit = (op_r == OP_COUNT_STATE) && (nst_r == PS_UNUSED);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_MAP;
      end
      S_MAP: begin
        if (op_r == OP_COUNT_STATE || op_r == OP_COUNT_LIVE) state_nxt = S_CNT;
        else state_nxt = S_SLOT;
      end
      S_SLOT: state_nxt = S_EVAL;
      S_CNT: begin
        if (cnt_r == CW'(SLOT_COUNT)) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result and table updates of the operation, applied when fire is high.
  always_comb begin
    res_c.status    = ST_OK;
    res_c.rpid      = '0;
    res_c.slot      = NO_SLOT;
    res_c.parent    = '0;
    res_c.pstate    = PS_UNUSED;
    res_c.exit_word = '0;
    res_c.count     = '0;
    do_create = 1'b0;
    do_update = 1'b0;
    do_reap   = 1'b0;
    do_setcur = 1'b0;
    rec_wd    = rec_q;
    case (op_r)
      OP_SPAWN, OP_FORK: begin
        if (op_r == OP_FORK && !live) begin
          res_c.status = ST_NOT_FOUND;
        end else if (!slot_avail_r) begin
          res_c.status = ST_NO_SLOT;
        end else if (!pid_avail_r) begin
          res_c.status = ST_NO_PID;
        end else begin
          // A live current process owns its slot, so the parent is the current pid either way.
          do_create        = 1'b1;
          rec_wd.owner     = free_pid_r;
          rec_wd.parent    = current_r;
          rec_wd.pstate    = PS_RUNNABLE;
          rec_wd.exit_word = '0;
          res_c.rpid       = W_RPID'(free_pid_r);
          res_c.slot       = W_SLOT'(free_slot_r);
          res_c.parent     = current_r;
          res_c.pstate     = PS_RUNNABLE;
        end
      end
      OP_SET_STATE, OP_EXIT, OP_LOOKUP, OP_REAP: begin
        if (!live) begin
          res_c.status = ST_NOT_FOUND;
        end else begin
          res_c.rpid      = W_RPID'(rec_q.owner);
          res_c.slot      = W_SLOT'(map_q);
          res_c.parent    = rec_q.parent;
          res_c.pstate    = rec_q.pstate;
          res_c.exit_word = rec_q.exit_word;
          if (op_r == OP_SET_STATE) begin
            do_update     = 1'b1;
            rec_wd.pstate = nst_r;
            res_c.pstate  = nst_r;
          end else if (op_r == OP_EXIT) begin
            do_update        = 1'b1;
            rec_wd.pstate    = PS_ZOMBIE;
            rec_wd.exit_word = ev_r;
            res_c.pstate     = PS_ZOMBIE;
            res_c.exit_word  = ev_r;
          end else if (op_r == OP_REAP) begin
            if (rec_q.pstate != PS_ZOMBIE) begin
              res_c.status = ST_NOT_ZOMBIE;
            end else begin
              // The slot bit goes clear, so the stale record reads as unused from now on.
              do_reap      = 1'b1;
              res_c.pstate = PS_UNUSED;
            end
          end
        end
      end
      OP_COUNT_STATE, OP_COUNT_LIVE: res_c.count = W_COUNT'(count_r);
      OP_SET_CURRENT: do_setcur = 1'b1;
      default: ;
    endcase
  end

  assign map_we = fire && do_create;
  assign rec_we = fire && (do_create || do_update);
  assign rec_wa = do_create ? free_slot_r : map_q;
  assign rec_re = (state_r == S_SLOT) || (state_r == S_CNT);
  assign rec_ra = (state_r == S_CNT) ? SW'(cnt_r) : map_q;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[free_pid_r] <= free_slot_r;
    if (state_r == S_MAP) map_q <= map_mem[lk_idx];
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (rec_re) rec_q <= rec_mem[rec_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      slot_used_r <= '0;
      pid_used_r  <= {{(PID_COUNT - 1){1'b0}}, 1'b1};
      current_r   <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        op_r         <= in_ch.opcode;
        pid_r        <= in_ch.target_pid;
        nst_r        <= in_ch.new_state;
        ev_r         <= in_ch.exit_value;
        free_slot_r  <= free_slot_c;
        slot_avail_r <= slot_avail_c;
        free_pid_r   <= free_pid_c;
        pid_avail_r  <= pid_avail_c;
      end
      case (state_r)
        S_MAP: begin
          cnt_r   <= '0;
          pend_r  <= 1'b0;
          count_r <= '0;
        end
        S_CNT: begin
          // Read one record a cycle; its data is tallied in the following cycle.
          if (cnt_hit) count_r <= count_r + 1'b1;
          if (cnt_r != CW'(SLOT_COUNT)) begin
            pend_r     <= 1'b1;
            pend_idx_r <= SW'(cnt_r);
            cnt_r      <= cnt_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
        end
        default: ;
      endcase
      if (fire) begin
        out_valid_r <= 1'b1;
        res_r       <= res_c;
        if (do_setcur) current_r <= pid_r;
        if (do_create) begin
          slot_used_r[free_slot_r] <= 1'b1;
          pid_used_r[free_pid_r]   <= 1'b1;
        end
        if (do_reap) begin
          slot_used_r[map_q]  <= 1'b0;
          pid_used_r[lk_idx]  <= 1'b0;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = res_r.status;
  assign out_ch.result_pid    = res_r.rpid;
  assign out_ch.result_slot   = res_r.slot;
  assign out_ch.parent_pid    = res_r.parent;
  assign out_ch.proc_state    = res_r.pstate;
  assign out_ch.exit_result   = res_r.exit_word;
  assign out_ch.process_count = res_r.count;

  `PST_ASSERT_NEXT(a_accept_starts_map, accept, state_r == S_MAP && op_r == $past(in_ch.opcode), "accepted transaction did not start a map read")
  `PST_ASSERT_SAME(a_bitmaps_agree, 1'b1, $countones(slot_used_r) + 1 == $countones(pid_used_r), "slot and pid bitmaps disagree")
  `PST_ASSERT_SAME(a_live_slot_used, state_r == S_EVAL && live, slot_used_r[map_q], "live process maps to a free slot")
  `PST_ASSERT_NEXT(a_fire_delivers, fire, out_valid_r && state_r == S_IDLE, "finished operation left no result")
  `PST_ASSERT_SAME(a_walk_bounded, state_r == S_CNT, cnt_r <= CW'(SLOT_COUNT), "slot walk ran past the table")

endmodule
